// ===== src/fp192_pkg.sv =====
`timescale 1ns / 1ps

package fp192_pkg;

  localparam int WORD_W  = 64;
  localparam int DIG_W   = 32;
  localparam int NUM_DIG = 6;
  localparam int OPND_W  = 3 * WORD_W;
  localparam int ROW_W   = OPND_W + DIG_W;
  localparam int PAIR_W  = ROW_W + DIG_W;
  localparam int SUM_W   = PAIR_W + 2 * DIG_W;
  localparam int KEEP_LO = 2 * WORD_W;
  localparam int CMD_W   = 2;

  localparam logic [CMD_W-1:0] CMD_ADD = 2'd0;
  localparam logic [CMD_W-1:0] CMD_SUB = 2'd1;
  localparam logic [CMD_W-1:0] CMD_MUL = 2'd2;

  // request control from the input register up to the output mux
  localparam int CTRL_DEPTH  = 5;
  // add/sub result register plus delay to line up with the multiplier
  localparam int ALIGN_DEPTH = 4;
  localparam int LATENCY     = CTRL_DEPTH + 1;

  typedef struct packed {
    logic             valid;
    logic [CMD_W-1:0] cmd;
  } ctrl_t;

endpackage

// ===== src/fixed_point_192_alu_core.sv =====
`timescale 1ns / 1ps

// pipeline: a request accepted at a clock edge goes through the input register,
// four more pipeline stages and the output register, then has its result on the
// out_ ports with out_valid
// throughput: one request per cycle, busy stays low; the receiver cannot stall
// reset: rst_n low at a clock edge clears all valid bits, data is not cleared

module fixed_point_192_alu_core (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  logic [fp192_pkg::CMD_W-1:0] in_cmd,
  input  logic [fp192_pkg::WORD_W-1:0] in_a_low,
  input  logic [fp192_pkg::WORD_W-1:0] in_a_mid,
  input  logic [fp192_pkg::WORD_W-1:0] in_a_high,
  input  logic [fp192_pkg::WORD_W-1:0] in_b_low,
  input  logic [fp192_pkg::WORD_W-1:0] in_b_mid,
  input  logic [fp192_pkg::WORD_W-1:0] in_b_high,
  output logic                        out_valid,
  output logic [fp192_pkg::WORD_W-1:0] out_res_low,
  output logic [fp192_pkg::WORD_W-1:0] out_res_mid,
  output logic [fp192_pkg::WORD_W-1:0] out_res_high
);

  localparam int W = fp192_pkg::WORD_W;

  fp192_pkg::ctrl_t             ctrl_r [fp192_pkg::CTRL_DEPTH];
  fp192_pkg::ctrl_t             ctrl_nxt;
  logic [fp192_pkg::OPND_W-1:0] a_r;
  logic [fp192_pkg::OPND_W-1:0] b_r;
  logic [fp192_pkg::OPND_W-1:0] as_res;
  logic [fp192_pkg::OPND_W-1:0] mul_res;
  logic [fp192_pkg::OPND_W-1:0] res_nxt;
  logic [fp192_pkg::OPND_W-1:0] res_r;
  logic                         valid_r;

  assign busy = 1'b0;

  always_comb begin
    ctrl_nxt.valid = start & ~busy;
    ctrl_nxt.cmd   = in_cmd;
  end

  always_ff @(posedge clk) begin
    a_r <= {in_a_high, in_a_mid, in_a_low};
    b_r <= {in_b_high, in_b_mid, in_b_low};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < fp192_pkg::CTRL_DEPTH; i++) begin
        ctrl_r[i].valid <= 1'b0;
        ctrl_r[i].cmd   <= fp192_pkg::CMD_ADD;
      end
      valid_r <= 1'b0;
    end else begin
      ctrl_r[0] <= ctrl_nxt;
      for (int i = 1; i < fp192_pkg::CTRL_DEPTH; i++) begin
        ctrl_r[i] <= ctrl_r[i-1];
      end
      valid_r <= ctrl_r[fp192_pkg::CTRL_DEPTH-1].valid;
    end
  end

  fp192_addsub u_addsub (
    .clk (clk),
    .sub (ctrl_r[0].cmd == fp192_pkg::CMD_SUB),
    .a   (a_r),
    .b   (b_r),
    .res (as_res)
  );

  fp192_mul u_mul (
    .clk  (clk),
    .a    (a_r),
    .b    (b_r),
    .prod (mul_res)
  );

  always_comb begin
    case (ctrl_r[fp192_pkg::CTRL_DEPTH-1].cmd)
      fp192_pkg::CMD_ADD: res_nxt = as_res;
      fp192_pkg::CMD_SUB: res_nxt = as_res;
      fp192_pkg::CMD_MUL: res_nxt = mul_res;
      default:            res_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
  end

  assign out_valid    = valid_r;
  assign out_res_low  = res_r[0*W +: W];
  assign out_res_mid  = res_r[1*W +: W];
  assign out_res_high = res_r[2*W +: W];

endmodule

// ===== src/fp192_addsub.sv =====
`timescale 1ns / 1ps

module fp192_addsub (
  input  logic                         clk,
  input  logic                         sub,
  input  logic [fp192_pkg::OPND_W-1:0] a,
  input  logic [fp192_pkg::OPND_W-1:0] b,
  output logic [fp192_pkg::OPND_W-1:0] res
);

  logic [fp192_pkg::OPND_W-1:0] res_r [fp192_pkg::ALIGN_DEPTH];

  always_ff @(posedge clk) begin
    res_r[0] <= sub ? (a - b) : (a + b);
    for (int i = 1; i < fp192_pkg::ALIGN_DEPTH; i++) begin
      res_r[i] <= res_r[i-1];
    end
  end

  assign res = res_r[fp192_pkg::ALIGN_DEPTH-1];

endmodule

// ===== src/fp192_mul.sv =====
`timescale 1ns / 1ps

module fp192_mul (
  input  logic                         clk,
  input  logic [fp192_pkg::OPND_W-1:0] a,
  input  logic [fp192_pkg::OPND_W-1:0] b,
  output logic [fp192_pkg::OPND_W-1:0] prod
);

  localparam int DW = fp192_pkg::DIG_W;
  localparam int ND = fp192_pkg::NUM_DIG;

  logic [2*DW-1:0]               pp_r   [ND][ND];
  logic [fp192_pkg::ROW_W-1:0]   row_nxt [ND];
  logic [fp192_pkg::ROW_W-1:0]   row_r   [ND];
  logic [fp192_pkg::PAIR_W-1:0]  pair_r  [ND/2];
  logic [fp192_pkg::SUM_W-1:0]   sum01_r;
  logic [fp192_pkg::OPND_W-1:0]  p2_r;

  // digit products
  always_ff @(posedge clk) begin
    for (int i = 0; i < ND; i++) begin
      for (int j = 0; j < ND; j++) begin
        pp_r[i][j] <= (2*DW)'(a[i*DW +: DW]) * (2*DW)'(b[j*DW +: DW]);
      end
    end
  end

  // even digit products do not overlap each other, nor do odd ones: one add per row
  always_comb begin
    for (int i = 0; i < ND; i++) begin
      row_nxt[i] = fp192_pkg::ROW_W'({pp_r[i][4], pp_r[i][2], pp_r[i][0]})
                 + {pp_r[i][5], pp_r[i][3], pp_r[i][1], {DW{1'b0}}};
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < ND; i++) begin
      row_r[i] <= row_nxt[i];
    end
    for (int k = 0; k < ND/2; k++) begin
      pair_r[k] <= fp192_pkg::PAIR_W'(row_r[2*k])
                 + {row_r[2*k+1], {DW{1'b0}}};
    end
    sum01_r <= fp192_pkg::SUM_W'(pair_r[0]) + {pair_r[1], {2*DW{1'b0}}};
    p2_r    <= pair_r[2][fp192_pkg::OPND_W-1:0];
  end

  // product bits 128 to 319; third pair enters at bit 128
  assign prod = sum01_r[fp192_pkg::SUM_W-1:fp192_pkg::KEEP_LO] + p2_r;

endmodule

// ===== src/fp192_chk.sv =====
`timescale 1ns / 1ps

module fp192_chk (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         start,
  input logic                         busy,
  input logic [fp192_pkg::CMD_W-1:0]  in_cmd,
  input logic [fp192_pkg::WORD_W-1:0] in_a_low,
  input logic [fp192_pkg::WORD_W-1:0] in_a_mid,
  input logic [fp192_pkg::WORD_W-1:0] in_a_high,
  input logic [fp192_pkg::WORD_W-1:0] in_b_low,
  input logic [fp192_pkg::WORD_W-1:0] in_b_mid,
  input logic [fp192_pkg::WORD_W-1:0] in_b_high,
  input logic                         out_valid,
  input logic [fp192_pkg::WORD_W-1:0] out_res_low,
  input logic [fp192_pkg::WORD_W-1:0] out_res_mid,
  input logic [fp192_pkg::WORD_W-1:0] out_res_high
);

  localparam int L = fp192_pkg::LATENCY;

  logic                         run_ok;
  logic [2:0]                   run_cnt_r;
  logic [2:0]                   run_cnt_nxt;
  logic                         req;
  logic [fp192_pkg::OPND_W-1:0] a_in;
  logic [fp192_pkg::OPND_W-1:0] b_in;
  logic [fp192_pkg::OPND_W-1:0] res;

  assign req  = start & ~busy;
  assign a_in = {in_a_high, in_a_mid, in_a_low};
  assign b_in = {in_b_high, in_b_mid, in_b_low};
  assign res  = {out_res_high, out_res_mid, out_res_low};

  // out of reset for the whole flight of a request
  assign run_cnt_nxt = (run_cnt_r == 3'(L)) ? run_cnt_r : run_cnt_r + 3'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_cnt_r <= 3'd0;
    end else begin
      run_cnt_r <= run_cnt_nxt;
    end
  end

  assign run_ok = (run_cnt_r == 3'(L));

  a_no_stall: assert property (@(posedge clk) disable iff (!rst_n) !busy)
    else $error("busy raised");

  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    run_ok |-> (out_valid == $past(req, L)))
    else $error("result strobe does not match request timing");

  a_add: assert property (@(posedge clk) disable iff (!rst_n)
    (run_ok && out_valid && $past(in_cmd, L) == fp192_pkg::CMD_ADD)
      |-> (res == $past(a_in, L) + $past(b_in, L)))
    else $error("add result wrong");

  a_sub: assert property (@(posedge clk) disable iff (!rst_n)
    (run_ok && out_valid && $past(in_cmd, L) == fp192_pkg::CMD_SUB)
      |-> (res == $past(a_in, L) - $past(b_in, L)))
    else $error("subtract result wrong");

  a_unused: assert property (@(posedge clk) disable iff (!rst_n)
    (run_ok && out_valid && $past(in_cmd, L) != fp192_pkg::CMD_ADD
      && $past(in_cmd, L) != fp192_pkg::CMD_SUB
      && $past(in_cmd, L) != fp192_pkg::CMD_MUL) |-> (res == '0))
    else $error("unused command gave nonzero result");

endmodule

bind fixed_point_192_alu_core fp192_chk u_fp192_chk (.*);

// ===== bench/tb_fixed_point_192_alu_core.sv =====
`timescale 1ns / 1ps

module tb_fixed_point_192_alu_core;

  localparam logic [fp192_pkg::CMD_W-1:0]  CMD_NONE  = 2'd3;
  localparam logic [fp192_pkg::WORD_W-1:0] WORD_ONES = '1;
  localparam int PROD_W     = 2 * fp192_pkg::OPND_W;
  localparam int IDLE_LIMIT = 200;

  logic                          clk;
  logic                          rst_n;
  logic                          start;
  logic                          busy;
  logic [fp192_pkg::CMD_W-1:0]   in_cmd;
  logic [fp192_pkg::WORD_W-1:0]  in_a_low, in_a_mid, in_a_high;
  logic [fp192_pkg::WORD_W-1:0]  in_b_low, in_b_mid, in_b_high;
  logic                          out_valid;
  logic [fp192_pkg::WORD_W-1:0]  out_res_low, out_res_mid, out_res_high;

  logic [fp192_pkg::OPND_W-1:0]  pending_results[$];
  int                            mismatches = 0;
  int                            burst_left = 0;
  int                            idle_cycles = 0;
  logic                          req_taken;

  fixed_point_192_alu_core uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_cmd       (in_cmd),
    .in_a_low     (in_a_low),
    .in_a_mid     (in_a_mid),
    .in_a_high    (in_a_high),
    .in_b_low     (in_b_low),
    .in_b_mid     (in_b_mid),
    .in_b_high    (in_b_high),
    .out_valid    (out_valid),
    .out_res_low  (out_res_low),
    .out_res_mid  (out_res_mid),
    .out_res_high (out_res_high)
  );

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  assign req_taken = start && !busy;

  function automatic logic [fp192_pkg::OPND_W-1:0] fp192_compute(
      logic [fp192_pkg::CMD_W-1:0] cmd,
      logic [fp192_pkg::OPND_W-1:0] a,
      logic [fp192_pkg::OPND_W-1:0] b);
    logic [PROD_W-1:0] prod;
    prod = '0;
    case (cmd)
      fp192_pkg::CMD_ADD: return a + b;
      fp192_pkg::CMD_SUB: return a - b;
      fp192_pkg::CMD_MUL: begin
        prod = {{fp192_pkg::OPND_W{1'b0}}, a} * {{fp192_pkg::OPND_W{1'b0}}, b};
        return prod[fp192_pkg::KEEP_LO +: fp192_pkg::OPND_W];
      end
      default: return '0;
    endcase
  endfunction

  function automatic logic [fp192_pkg::WORD_W-1:0] pick_word();
    int sel;
    int k;
    sel = $urandom_range(0, 9);
    k = $urandom_range(0, fp192_pkg::WORD_W - 1);
    case (sel)
      0: return '0;
      1: return '1;
      2: return 64'd1 << k;
      3: return ~(64'd1 << k);
      4: return 64'($urandom_range(0, 15));
      default: return {$urandom, $urandom};
    endcase
  endfunction

  function automatic logic [fp192_pkg::OPND_W-1:0] pick_operand();
    return {pick_word(), pick_word(), pick_word()};
  endfunction

  task automatic report_mismatch(string what, logic [fp192_pkg::WORD_W-1:0] got,
                                 logic [fp192_pkg::WORD_W-1:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
    mismatches++;
  endtask

  task automatic drive_noise();
    in_cmd    <= fp192_pkg::CMD_W'($urandom);
    in_a_low  <= {$urandom, $urandom};
    in_a_mid  <= {$urandom, $urandom};
    in_a_high <= {$urandom, $urandom};
    in_b_low  <= {$urandom, $urandom};
    in_b_mid  <= {$urandom, $urandom};
    in_b_high <= {$urandom, $urandom};
  endtask

  task automatic send_req(logic [fp192_pkg::CMD_W-1:0] cmd,
                          logic [fp192_pkg::OPND_W-1:0] a,
                          logic [fp192_pkg::OPND_W-1:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        @(negedge clk);
        start <= 1'b0;
        drive_noise();
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    burst_left--;
    @(negedge clk);
    start     <= 1'b1;
    in_cmd    <= cmd;
    in_a_low  <= a[0 +: fp192_pkg::WORD_W];
    in_a_mid  <= a[fp192_pkg::WORD_W +: fp192_pkg::WORD_W];
    in_a_high <= a[2*fp192_pkg::WORD_W +: fp192_pkg::WORD_W];
    in_b_low  <= b[0 +: fp192_pkg::WORD_W];
    in_b_mid  <= b[fp192_pkg::WORD_W +: fp192_pkg::WORD_W];
    in_b_high <= b[2*fp192_pkg::WORD_W +: fp192_pkg::WORD_W];
    forever begin
      @(posedge clk);
      if (!busy) break;
    end
    pending_results.push_back(fp192_compute(cmd, a, b));
  endtask

  always @(posedge clk) begin
    logic [fp192_pkg::OPND_W-1:0] want;
    if (rst_n && out_valid) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result res_low", out_res_low, '0);
      end else begin
        want = pending_results.pop_front();
        if (out_res_low !== want[0 +: fp192_pkg::WORD_W])
          report_mismatch("res_low", out_res_low, want[0 +: fp192_pkg::WORD_W]);
        if (out_res_mid !== want[fp192_pkg::WORD_W +: fp192_pkg::WORD_W])
          report_mismatch("res_mid", out_res_mid,
                          want[fp192_pkg::WORD_W +: fp192_pkg::WORD_W]);
        if (out_res_high !== want[2*fp192_pkg::WORD_W +: fp192_pkg::WORD_W])
          report_mismatch("res_high", out_res_high,
                          want[2*fp192_pkg::WORD_W +: fp192_pkg::WORD_W]);
      end
    end
  end

  always @(posedge clk) begin
    if (req_taken || out_valid)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("timeout with %0d results outstanding", pending_results.size());
      $display("tb_fixed_point_192_alu_core failed");
      $finish;
    end
  end

  task automatic test_directed();
    logic [fp192_pkg::OPND_W-1:0] ones;
    logic [fp192_pkg::OPND_W-1:0] one_int;
    ones = '1;
    one_int = {64'd1, 64'd0, 64'd0};
    send_req(fp192_pkg::CMD_ADD, '0, '0);
    send_req(fp192_pkg::CMD_ADD, ones, ones);
    // carry through all words, wrapped out
    send_req(fp192_pkg::CMD_ADD, ones, 192'd1);
    send_req(fp192_pkg::CMD_ADD, {64'd0, 64'd0, WORD_ONES}, 192'd1);
    send_req(fp192_pkg::CMD_ADD, {64'd0, WORD_ONES, WORD_ONES}, 192'd1);
    send_req(fp192_pkg::CMD_SUB, '0, '0);
    // borrow out of the top, wrapped
    send_req(fp192_pkg::CMD_SUB, '0, 192'd1);
    send_req(fp192_pkg::CMD_SUB, {64'd0, 64'd1, 64'd0}, 192'd1);
    send_req(fp192_pkg::CMD_SUB, {64'd1, 64'd0, 64'd0}, 192'd1);
    send_req(fp192_pkg::CMD_SUB, ones, ones);
    send_req(fp192_pkg::CMD_SUB, '0, ones);
    send_req(fp192_pkg::CMD_MUL, '0, ones);
    send_req(fp192_pkg::CMD_MUL, ones, ones);
    send_req(fp192_pkg::CMD_MUL, one_int, one_int);
    send_req(fp192_pkg::CMD_MUL, one_int, ones);
    // low fraction bits truncated away
    send_req(fp192_pkg::CMD_MUL, 192'd1, 192'd1);
    send_req(fp192_pkg::CMD_MUL, {64'd0, 64'd1, 64'd0}, {64'd0, 64'd1, 64'd0});
    // integer part overflows and wraps
    send_req(fp192_pkg::CMD_MUL, {WORD_ONES, 64'd0, 64'd0}, {WORD_ONES, 64'd0, 64'd0});
    send_req(fp192_pkg::CMD_MUL, {64'h8000_0000_0000_0000, 128'd0}, {64'd2, 128'd0});
    // unused command gives zero
    send_req(CMD_NONE, ones, ones);
    send_req(CMD_NONE, pick_operand(), one_int);
  endtask

  task automatic test_random_mixed(int n);
    repeat (n)
      send_req(fp192_pkg::CMD_W'($urandom_range(0, 3)), pick_operand(), pick_operand());
  endtask

  task automatic test_carry_chains(int n);
    logic [fp192_pkg::OPND_W-1:0] a;
    logic [fp192_pkg::OPND_W-1:0] b;
    repeat (n) begin
      a = pick_operand();
      case ($urandom_range(0, 3))
        0: b = ~a;
        1: b = ~a + fp192_pkg::OPND_W'($urandom_range(1, 3));
        2: b = a;
        default: b = a + fp192_pkg::OPND_W'($urandom_range(0, 1));
      endcase
      send_req(($urandom_range(0, 1) == 0) ? fp192_pkg::CMD_ADD : fp192_pkg::CMD_SUB,
               a, b);
    end
  endtask

  task automatic test_random_mul(int n);
    logic [fp192_pkg::OPND_W-1:0] a;
    logic [fp192_pkg::OPND_W-1:0] b;
    repeat (n) begin
      a = {{$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom}};
      b = ($urandom_range(0, 1) == 0) ? pick_operand()
          : {{$urandom, $urandom}, {$urandom, $urandom}, {$urandom, $urandom}};
      // small integer parts keep the product in range
      if ($urandom_range(0, 2) == 0) begin
        a[2*fp192_pkg::WORD_W +: fp192_pkg::WORD_W] = 64'($urandom_range(0, 255));
        b[2*fp192_pkg::WORD_W +: fp192_pkg::WORD_W] = 64'($urandom_range(0, 255));
      end
      send_req(fp192_pkg::CMD_MUL, a, b);
    end
  endtask

  initial begin
    rst_n = 1'b0;
    start = 1'b0;
    in_cmd = fp192_pkg::CMD_ADD;
    in_a_low = '0;
    in_a_mid = '0;
    in_a_high = '0;
    in_b_low = '0;
    in_b_mid = '0;
    in_b_high = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_random_mixed(900);
    test_carry_chains(350);
    test_random_mul(430);

    @(negedge clk);
    start <= 1'b0;
    wait (pending_results.size() == 0);
    repeat (fp192_pkg::LATENCY + 4) @(posedge clk);
    if (mismatches == 0)
      $display("tb_fixed_point_192_alu_core passed");
    else
      $display("tb_fixed_point_192_alu_core failed");
    $finish;
  end

endmodule

// ===== fixed_point_192_alu_core.f =====
src/fp192_pkg.sv
src/fp192_addsub.sv
src/fp192_mul.sv
src/fixed_point_192_alu_core.sv
src/fp192_chk.sv
bench/tb_fixed_point_192_alu_core.sv
